// ===== rtl/cconv_pkg.sv =====
// Shared types and constants for the circular convolution block.
package cconv_pkg;

    // Fixed field widths of the ports.
    localparam int CFG_W     = 7;
    localparam int VAL_W     = 38;
    localparam int OUT_IDX_W = 6;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } cconv_state_t;

    // Control group broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;      // a sample pair is written this cycle
        logic mul;       // rotate the sample rings during the multiply pass
        logic acc_clr;   // clear the accumulators
        logic acc_en;    // add the registered product into the accumulator
        logic shift;     // move accumulators one cell toward cell 0
    } cconv_cell_ctrl_t;

endpackage

// ===== rtl/cconv_cell.sv =====
// One cell of the multiply-accumulate chain: a sample of each ring and one result.
module cconv_cell
    import cconv_pkg::*;
#(
    parameter int CELL_IDX    = 0,
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 38,
    parameter int IDX_W       = 6
) (
    input  logic                          aclk,
    input  cconv_cell_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]              last_idx,
    input  logic [IDX_W-1:0]              wr_idx_a,
    input  logic [IDX_W-1:0]              wr_idx_b,
    input  logic signed [SAMPLE_BITS-1:0] sample_a,
    input  logic signed [SAMPLE_BITS-1:0] sample_b,
    input  logic signed [SAMPLE_BITS-1:0] a_first,
    input  logic signed [SAMPLE_BITS-1:0] a_right,
    input  logic signed [SAMPLE_BITS-1:0] b_first,
    input  logic signed [SAMPLE_BITS-1:0] b_right,
    input  logic signed [SAMPLE_BITS-1:0] a_bcast,
    input  logic signed [ACC_W-1:0]       acc_right,
    output logic signed [SAMPLE_BITS-1:0] a_out,
    output logic signed [SAMPLE_BITS-1:0] b_out,
    output logic signed [ACC_W-1:0]       acc_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic signed [SAMPLE_BITS-1:0]   a_reg, a_next;
    logic signed [SAMPLE_BITS-1:0]   b_reg, b_next;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    logic                            is_last;

    // The cell at the end of the active length wraps around to cell 0.
    assign is_last = (MY_IDX == last_idx);

    // Sample rings: written by address while loading, rotated while multiplying.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        if (ctrl.load) begin
            if (wr_idx_a == MY_IDX) begin
                a_next = sample_a;
            end
            if (wr_idx_b == MY_IDX) begin
                b_next = sample_b;
            end
        end else if (ctrl.mul) begin
            a_next = is_last ? a_first : a_right;
            b_next = is_last ? b_first : b_right;
        end
    end

    // Product of the broadcast sample with this cell's sample of the second ring.
    assign prod_next = a_bcast * b_reg;

    // Accumulator: cleared before a sequence, summed, then shifted out.
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.acc_clr) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end else if (ctrl.shift) begin
            acc_next = acc_right;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;

endmodule

// ===== rtl/circular_convolution.sv =====
// Top level of the circular convolution block: sequencer, cell chain and output register.
//
// The block loads one sample pair per request, L requests for a sequence of length L
// (set by seq_length, 0 acting as 1 and values above MAX_LEN acting as MAX_LEN). After
// the request that completes the sequence the input stalls while the chain of MAX_LEN
// cells works: each cell owns one result, one multiplier and one sample of each ring,
// and the sums build up over a serial multiply pass and a final accumulate. The L results
// then shift out of cell 0 through the output register, one per cycle while m_ready is
// high, in index order with m_last on the final one. No new request is taken until
// the serial multiply pass and the serial drain of the chain are through. Loading of
// the next sequence starts as soon as the last result sits in the output register.
// Writing seq_length restarts loading.
module circular_convolution
    import cconv_pkg::*;
#(
    parameter int MAX_LEN     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample_a,
    input  logic [SAMPLE_BITS-1:0] s_sample_b,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VAL_W-1:0]       m_conv_value,
    output logic [OUT_IDX_W-1:0]   m_out_index,
    output logic                   m_last
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(MAX_LEN);
    localparam int EXT_W = (ACC_W > VAL_W) ? ACC_W : VAL_W;
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration and sequencer registers.
    logic [CFG_W-1:0]   seq_length_reg, seq_length_next;
    cconv_state_t       state_reg, state_next;
    logic [LEN_W-1:0]   load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic               acc_en_reg, acc_en_next;
    logic               m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]   m_value_reg, m_value_next;
    logic [IDX_W-1:0]   m_index_reg, m_index_next;
    logic               m_last_reg, m_last_next;

    logic [CFG_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len;
    logic [IDX_W-1:0]   last_idx;
    logic [LEN_W-1:0]   load_cnt_inc;
    logic [IDX_W-1:0]   wr_idx_a;
    logic [IDX_W-1:0]   wr_idx_b;
    logic               in_fire;
    logic               load_done;
    logic               out_room;
    cconv_cell_ctrl_t   ctrl;

    logic signed [SAMPLE_BITS-1:0] a_q   [MAX_LEN];
    logic signed [SAMPLE_BITS-1:0] b_q   [MAX_LEN];
    logic signed [ACC_W-1:0]       acc_q [MAX_LEN];

    logic signed [EXT_W-1:0]       acc_ext;
    logic [EXT_W-VAL_W:0]          acc_top;
    logic [VAL_W-1:0]              sat_value;

    // Active length: zero acts as one, anything above the chain length is clipped.
    always_comb begin
        if (seq_length_reg == '0) begin
            len_raw = CFG_W'(1);
        end else if (seq_length_reg > CFG_W'(MAX_LEN)) begin
            len_raw = CFG_W'(MAX_LEN);
        end else begin
            len_raw = seq_length_reg;
        end
    end
    assign len      = LEN_W'(len_raw);
    assign last_idx = IDX_W'(len - LEN_W'(1));

    // Load addressing: the first ring is stored negated in index so that
    // rotating it toward cell 0 presents a[0], a[L-1], ..., a[1].
    assign load_cnt_inc = load_cnt_reg + LEN_W'(1);
    assign wr_idx_b     = load_cnt_reg[IDX_W-1:0];
    assign wr_idx_a     = (load_cnt_reg == '0) ? '0 : IDX_W'(len - load_cnt_reg);

    assign in_fire   = s_valid && s_ready;
    assign load_done = in_fire && (load_cnt_inc == len);
    assign out_room  = !m_valid_reg || m_ready;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (load_done) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (step_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_room && (step_reg == last_idx)) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs of the sequencer: cell control and input handshake.
    always_comb begin
        s_ready      = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.mul     = 1'b0;
        ctrl.acc_clr = 1'b0;
        ctrl.acc_en  = acc_en_reg;
        ctrl.shift   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready      = 1'b1;
                ctrl.load    = in_fire;
                ctrl.acc_clr = load_done;
            end
            ST_MAC: begin
                ctrl.mul = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_EMIT: begin
                ctrl.shift = out_room;
            end
            default: begin
            end
        endcase
    end

    // Counters and configuration register.
    always_comb begin
        seq_length_next = seq_length_reg;
        load_cnt_next   = load_cnt_reg;
        step_next       = step_reg;
        acc_en_next     = (state_reg == ST_MAC);
        if (cfg_we) begin
            seq_length_next = cfg_wdata;
            load_cnt_next   = '0;
        end else if (in_fire) begin
            load_cnt_next = load_done ? '0 : load_cnt_inc;
        end
        if (state_reg == ST_LOAD || state_reg == ST_DRAIN) begin
            step_next = '0;
        end else if (state_reg == ST_MAC) begin
            step_next = step_reg + IDX_W'(1);
        end else if (out_room) begin
            step_next = step_reg + IDX_W'(1);
        end
    end

    // Saturate the sum of cell 0 to the result width.
    assign acc_ext = EXT_W'(acc_q[0]);
    assign acc_top = acc_ext[EXT_W-1:VAL_W-1];
    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            sat_value = acc_ext[VAL_W-1:0];
        end else if (acc_ext[EXT_W-1]) begin
            sat_value = VAL_MIN;
        end else begin
            sat_value = VAL_MAX;
        end
    end

    // Output register, loaded from cell 0 as the chain drains.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_index_next = m_index_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_EMIT && out_room) begin
            m_valid_next = 1'b1;
            m_value_next = sat_value;
            m_index_next = step_reg;
            m_last_next  = (step_reg == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg <= CFG_W'(64);
            state_reg      <= ST_LOAD;
            load_cnt_reg   <= '0;
            step_reg       <= '0;
            acc_en_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            seq_length_reg <= seq_length_next;
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            step_reg       <= step_next;
            acc_en_reg     <= acc_en_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    // The chain of cells; cell 0 broadcasts its sample of the first ring.
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        logic signed [ACC_W-1:0] acc_right;
        if (k == MAX_LEN - 1) begin : g_end
            assign acc_right = '0;
        end else begin : g_mid
            assign acc_right = acc_q[k+1];
        end

        cconv_cell #(
            .CELL_IDX    (k),
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W),
            .IDX_W       (IDX_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .last_idx  (last_idx),
            .wr_idx_a  (wr_idx_a),
            .wr_idx_b  (wr_idx_b),
            .sample_a  ($signed(s_sample_a)),
            .sample_b  ($signed(s_sample_b)),
            .a_first   (a_q[0]),
            .a_right   (a_q[(k+1) % MAX_LEN]),
            .b_first   (b_q[0]),
            .b_right   (b_q[(k+1) % MAX_LEN]),
            .a_bcast   (a_q[0]),
            .acc_right (acc_right),
            .a_out     (a_q[k]),
            .b_out     (b_q[k]),
            .acc_out   (acc_q[k])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_conv_value = m_value_reg;
    assign m_out_index  = OUT_IDX_W'(m_index_reg);
    assign m_last       = m_last_reg;

endmodule
